// ----- src/i2cm_pkg.sv -----
// Shared types and constants for the register-addressed I2C master.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_BYTE  = 2'd3;

  // Configuration register map.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_PHASES  = 1'd1;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
  localparam logic [7:0]  GAP_PHASES_RESET  = 8'd10;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_BIT_LOW,
    PH_BIT_HIGH,
    PH_ACK_LOW,
    PH_ACK_HIGH,
    PH_GAP,
    PH_WAIT,
    PH_RS_LOW,
    PH_RS_HIGH,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_MACK_LOW,
    PH_MACK_HIGH,
    PH_STOP_LOW,
    PH_STOP_HIGH
  } phase_t;

  typedef enum logic [2:0] {
    STG_ADDR,
    STG_SUB,
    STG_DATA,
    STG_RADDR,
    STG_READ
  } stage_t;

  typedef struct packed {
    phase_t      bus_phase;
    logic [15:0] phase_timer;
    logic [3:0]  bit_counter;
    logic [7:0]  shift_reg;
    logic [7:0]  bytes_left;
    logic [7:0]  target_addr;
    logic [7:0]  register_addr;
    logic        is_read;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic        nack_flag;
    logic        fault_flag;
    stage_t      stage;
    logic [7:0]  gap_left;
  } i2cm_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slave_addr;
    logic [7:0] sub_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       byte_request;
    logic       busy_res;
    logic       done_res;
    logic       no_ack;
    logic       bus_fault;
  } out_item_t;

endpackage

// ----- src/i2cm_step.sv -----
// One-item update of the I2C master state and the result it produces.
`timescale 1ns / 1ps

module i2cm_step import i2cm_pkg::*; (
  input  i2cm_state_t st,
  input  in_item_t    item,
  input  logic [15:0] phase_ticks,
  input  logic [7:0]  gap_phases,
  output i2cm_state_t st_next,
  output out_item_t   res
);

  logic [15:0] unit_len;
  logic [3:0]  bc_inc;
  logic [7:0]  rd_shift;
  logic        do_after_ack;
  logic        do_next_action;
  logic        do_begin_data;

  // A unit length of zero behaves as one tick.
  assign unit_len = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign bc_inc   = st.bit_counter + 4'd1;
  assign rd_shift = {st.shift_reg[6:0], item.sda_in};

  always_comb begin
    st_next        = st;
    res            = '0;
    do_after_ack   = 1'b0;
    do_next_action = 1'b0;
    do_begin_data  = 1'b0;

    unique case (item.kind)
      KIND_BYTE: begin
        st_next.held_byte  = item.write_byte;
        st_next.held_valid = 1'b1;
      end
      KIND_WRITE, KIND_READ: begin
        if (st.bus_phase == PH_IDLE) begin
          st_next.nack_flag     = 1'b0;
          st_next.target_addr   = item.slave_addr;
          st_next.register_addr = item.sub_addr;
          st_next.bytes_left    = item.byte_count;
          st_next.is_read       = (item.kind == KIND_READ);
          st_next.stage         = STG_ADDR;
          st_next.bit_counter   = 4'd0;
          st_next.gap_left      = 8'd0;
          st_next.phase_timer   = unit_len;
          // Either line held low by someone else means the bus is not free.
          if (!item.scl_in || !item.sda_in) begin
            st_next.fault_flag = 1'b1;
            st_next.bus_phase  = PH_STOP_LOW;
          end else begin
            st_next.fault_flag = 1'b0;
            st_next.bus_phase  = PH_START;
          end
        end
      end
      default: begin
        if (st.bus_phase == PH_WAIT) begin
          do_begin_data = st.held_valid;
        end else if (st.bus_phase != PH_IDLE) begin
          if (st.phase_timer > 16'd1) begin
            st_next.phase_timer = st.phase_timer - 16'd1;
          end else begin
            st_next.phase_timer = unit_len;
            unique case (st.bus_phase)
              PH_START: begin
                st_next.shift_reg   = (st.stage == STG_RADDR) ?
                                      (st.target_addr | 8'd1) : st.target_addr;
                st_next.bit_counter = 4'd0;
                st_next.bus_phase   = PH_BIT_LOW;
              end
              PH_BIT_LOW: st_next.bus_phase = PH_BIT_HIGH;
              PH_BIT_HIGH: begin
                st_next.shift_reg   = {st.shift_reg[6:0], 1'b0};
                st_next.bit_counter = bc_inc;
                st_next.bus_phase   = (bc_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
              end
              PH_ACK_LOW: st_next.bus_phase = PH_ACK_HIGH;
              PH_ACK_HIGH: begin
                if (item.sda_in) begin
                  st_next.nack_flag = 1'b1;
                  st_next.bus_phase = PH_STOP_LOW;
                end else begin
                  do_after_ack = 1'b1;
                end
              end
              PH_GAP: begin
                if (st.gap_left > 8'd1) begin
                  st_next.gap_left = st.gap_left - 8'd1;
                end else begin
                  st_next.gap_left = 8'd0;
                  do_next_action   = 1'b1;
                end
              end
              PH_RS_LOW: st_next.bus_phase = PH_RS_HIGH;
              PH_RS_HIGH: begin
                if (!item.scl_in || !item.sda_in) begin
                  st_next.fault_flag = 1'b1;
                  st_next.bus_phase  = PH_STOP_LOW;
                end else begin
                  st_next.stage     = STG_RADDR;
                  st_next.bus_phase = PH_START;
                end
              end
              PH_RD_LOW: st_next.bus_phase = PH_RD_HIGH;
              PH_RD_HIGH: begin
                st_next.shift_reg   = rd_shift;
                st_next.bit_counter = bc_inc;
                if (bc_inc >= BITS_PER_BYTE) begin
                  res.read_data     = rd_shift;
                  res.read_valid    = 1'b1;
                  res.read_last     = (st.bytes_left == 8'd1);
                  st_next.bus_phase = PH_MACK_LOW;
                end else begin
                  st_next.bus_phase = PH_RD_LOW;
                end
              end
              PH_MACK_LOW: st_next.bus_phase = PH_MACK_HIGH;
              PH_MACK_HIGH: begin
                if (st.bytes_left != 8'd0) begin
                  st_next.bytes_left = st.bytes_left - 8'd1;
                end
                do_after_ack = 1'b1;
              end
              PH_STOP_LOW: st_next.bus_phase = PH_STOP_HIGH;
              PH_STOP_HIGH: begin
                st_next.bus_phase   = PH_IDLE;
                st_next.phase_timer = 16'd0;
                res.done_res        = 1'b1;
              end
              default: begin
                st_next.bus_phase   = PH_IDLE;
                st_next.phase_timer = 16'd0;
              end
            endcase
          end
        end
      end
    endcase

    // After an acknowledge either idle for the gap or move on at once.
    if (do_after_ack) begin
      if (gap_phases == 8'd0) begin
        do_next_action = 1'b1;
      end else begin
        st_next.gap_left    = gap_phases;
        st_next.bus_phase   = PH_GAP;
        st_next.phase_timer = unit_len;
      end
    end

    if (do_next_action) begin
      st_next.phase_timer = unit_len;
      unique case (st_next.stage)
        STG_ADDR: begin
          st_next.stage       = STG_SUB;
          st_next.shift_reg   = st_next.register_addr;
          st_next.bit_counter = 4'd0;
          st_next.bus_phase   = PH_BIT_LOW;
        end
        STG_SUB: begin
          if (st_next.is_read) begin
            st_next.bus_phase = PH_RS_LOW;
          end else begin
            do_begin_data = 1'b1;
          end
        end
        STG_DATA: do_begin_data = 1'b1;
        STG_RADDR, STG_READ: begin
          if (st_next.bytes_left != 8'd0) begin
            st_next.stage       = STG_READ;
            st_next.bit_counter = 4'd0;
            st_next.bus_phase   = PH_RD_LOW;
          end else begin
            st_next.bus_phase = PH_STOP_LOW;
          end
        end
        default: st_next.bus_phase = PH_STOP_LOW;
      endcase
    end

    // Stop when no bytes remain, else fetch the next write byte, or hold SCL low until one is supplied.
    if (do_begin_data) begin
      priority if (st_next.bytes_left == 8'd0) begin
        st_next.bus_phase   = PH_STOP_LOW;
        st_next.phase_timer = unit_len;
      end else if (st_next.held_valid) begin
        st_next.held_valid  = 1'b0;
        st_next.bytes_left  = st_next.bytes_left - 8'd1;
        st_next.stage       = STG_DATA;
        st_next.shift_reg   = st_next.held_byte;
        st_next.bit_counter = 4'd0;
        st_next.bus_phase   = PH_BIT_LOW;
        st_next.phase_timer = unit_len;
      end else begin
        st_next.bus_phase   = PH_WAIT;
        st_next.phase_timer = 16'd0;
      end
    end

    unique case (st_next.bus_phase)
      PH_START: begin
        res.scl_out = 1'b1;
        res.sda_out = 1'b0;
      end
      PH_BIT_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = st_next.shift_reg[7];
      end
      PH_BIT_HIGH: begin
        res.scl_out = 1'b1;
        res.sda_out = st_next.shift_reg[7];
      end
      PH_ACK_LOW, PH_GAP, PH_WAIT, PH_RS_LOW, PH_RD_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = 1'b1;
      end
      PH_MACK_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = (st_next.bytes_left == 8'd1);
      end
      PH_MACK_HIGH: begin
        res.scl_out = 1'b1;
        res.sda_out = (st_next.bytes_left == 8'd1);
      end
      PH_STOP_LOW: begin
        res.scl_out = 1'b0;
        res.sda_out = 1'b0;
      end
      PH_STOP_HIGH: begin
        res.scl_out = 1'b1;
        res.sda_out = 1'b0;
      end
      default: begin
        res.scl_out = 1'b1;
        res.sda_out = 1'b1;
      end
    endcase

    res.byte_request = (st_next.bus_phase == PH_WAIT) && !st_next.held_valid;
    res.busy_res     = (st_next.bus_phase != PH_IDLE);
    res.no_ack       = st_next.nack_flag;
    res.bus_fault    = st_next.fault_flag;
  end

endmodule

// ----- src/i2c_master_register_transfer.sv -----
// I2C master for register-addressed transfers: top level with state and result registers.
//
// Usage: every input item is a tick (sampled SCL/SDA), a start command (write or
// read, with slave address, sub-address and byte count) or a write byte. Each
// accepted item yields exactly one result item carrying the driven SCL/SDA
// levels, any received byte and the transfer status flags. Bus timing is set
// in ticks through the configuration port (phase_ticks, gap_phases), which is
// always ready; the user writes it only while idle, which the block does not enforce.
// Throughput: one item per clock while the output is not stalled. Each item
// passes through the input register and then the result register, with the
// whole state update done in a single pass in between.
// Reset (rst, synchronous) puts the master idle with both lines released and
// restores the default timing registers.
// When the receiver stalls, the result is held and the input register still
// takes one more item; in_stall rises only while both registers are full.
`timescale 1ns / 1ps

module i2c_master_register_transfer import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] phase_ticks;
  logic [7:0]  gap_phases;
  logic        in_q_valid;
  in_item_t    in_q;
  logic        advance;
  i2cm_state_t st;
  i2cm_state_t st_next;
  out_item_t   res;

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
      gap_phases  <= GAP_PHASES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PHASE_TICKS: phase_ticks <= cfg_data;
        CFG_GAP_PHASES:  gap_phases  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_item;
    end
  end

  i2cm_step u_step (
    .st          (st),
    .item        (in_q),
    .phase_ticks (phase_ticks),
    .gap_phases  (gap_phases),
    .st_next     (st_next),
    .res         (res)
  );

  // The held write byte has no reset; it is only read while held_valid is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.bus_phase     <= PH_IDLE;
      st.phase_timer   <= 16'd0;
      st.bit_counter   <= 4'd0;
      st.shift_reg     <= 8'd0;
      st.bytes_left    <= 8'd0;
      st.target_addr   <= 8'd0;
      st.register_addr <= 8'd0;
      st.is_read       <= 1'b0;
      st.held_valid    <= 1'b0;
      st.nack_flag     <= 1'b0;
      st.fault_flag    <= 1'b0;
      st.stage         <= STG_ADDR;
      st.gap_left      <= 8'd0;
    end else if (advance) begin
      st.bus_phase     <= st_next.bus_phase;
      st.phase_timer   <= st_next.phase_timer;
      st.bit_counter   <= st_next.bit_counter;
      st.shift_reg     <= st_next.shift_reg;
      st.bytes_left    <= st_next.bytes_left;
      st.target_addr   <= st_next.target_addr;
      st.register_addr <= st_next.register_addr;
      st.is_read       <= st_next.is_read;
      st.held_valid    <= st_next.held_valid;
      st.nack_flag     <= st_next.nack_flag;
      st.fault_flag    <= st_next.fault_flag;
      st.stage         <= st_next.stage;
      st.gap_left      <= st_next.gap_left;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st.held_byte <= st_next.held_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  // The input side only stalls while a finished result is being held.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A received byte is reported as the master drives its acknowledge with SCL low.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.read_valid) |-> !out_item.scl_out)
    else $error("read byte reported with SCL high");

  // While waiting for a write byte the clock is stretched low and SDA released.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.byte_request) |->
      (out_item.busy_res && !out_item.scl_out && out_item.sda_out))
    else $error("byte request without a stretched clock");

  // A completed stop leaves the bus released and the master idle.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.done_res) |->
      (out_item.scl_out && out_item.sda_out && !out_item.busy_res))
    else $error("stop completed without releasing the bus");

endmodule
